// ----- hw/rtl/bmp24_pkg.sv -----
// Package: shared types, constants and byte selection for the BMP stream encoder.
`default_nettype none
package bmp24_pkg;

  // Dimension registers and counters
  localparam int DIM_W  = 13;
  localparam int POS_W  = 6;
  localparam int IMG_W  = 28;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Byte positions within the sequence of one pixel
  localparam logic [POS_W-1:0] HDR_BYTES  = 6'd54;
  localparam logic [POS_W-1:0] PIX_FIRST  = 6'd54;
  localparam logic [POS_W-1:0] PIX_LAST   = 6'd56;

  // Header constants
  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [31:0] BITMAP_START = 32'd54;
  localparam logic [7:0]  INFO_SIZE    = 8'd40;
  localparam logic [7:0]  PLANES       = 8'd1;
  localparam logic [7:0]  BITS_PIXEL   = 8'd24;
  localparam logic [15:0] PIX_PER_M    = 16'd2835;
  localparam logic [7:0]  NO_HEIGHT    = 8'd255;
  localparam logic [7:0]  BAD_POINT    = 8'd127;

  // One pixel held for emission, with everything its bytes need
  typedef struct packed {
    logic             point_valid;
    logic             height_nonzero;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] last_pos;
    logic             img_end;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [IMG_W-1:0] img_size;
  } item_t;

  // Header byte at a given offset, little-endian fields
  function automatic logic [7:0] header_byte(input logic [POS_W-1:0] idx,
                                             input logic [31:0] total_len,
                                             input logic [31:0] width,
                                             input logic [31:0] height,
                                             input logic [31:0] img_size);
    logic [7:0] b;
    b = 8'd0;
    unique case (idx)
      6'd0:  b = MAGIC_B;
      6'd1:  b = MAGIC_M;
      6'd2:  b = total_len[7:0];
      6'd3:  b = total_len[15:8];
      6'd4:  b = total_len[23:16];
      6'd5:  b = total_len[31:24];
      6'd10: b = BITMAP_START[7:0];
      6'd14: b = INFO_SIZE;
      6'd18: b = width[7:0];
      6'd19: b = width[15:8];
      6'd20: b = width[23:16];
      6'd21: b = width[31:24];
      6'd22: b = height[7:0];
      6'd23: b = height[15:8];
      6'd24: b = height[23:16];
      6'd25: b = height[31:24];
      6'd26: b = PLANES;
      6'd28: b = BITS_PIXEL;
      6'd34: b = img_size[7:0];
      6'd35: b = img_size[15:8];
      6'd36: b = img_size[23:16];
      6'd37: b = img_size[31:24];
      6'd38: b = PIX_PER_M[7:0];
      6'd39: b = PIX_PER_M[15:8];
      6'd42: b = PIX_PER_M[7:0];
      6'd43: b = PIX_PER_M[15:8];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bmp24_pix_if.sv -----
// Interface: pixel channel into the encoder.
`default_nettype none
interface bmp24_pix_if;
  logic       valid;
  logic       ready;
  logic       point_x_nonzero;
  logic       point_y_nonzero;
  logic       height_nonzero;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, point_x_nonzero, point_y_nonzero, height_nonzero,
                  red, green, blue, input ready);
  modport sink   (input valid, point_x_nonzero, point_y_nonzero, height_nonzero,
                  red, green, blue, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bmp24_byte_if.sv -----
// Interface: byte stream channel out of the encoder.
`default_nettype none
interface bmp24_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       image_done;

  modport source (output valid, out_byte, last_of_item, image_done, input ready);
  modport sink   (input valid, out_byte, last_of_item, image_done, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bmp24_byte_sel.sv -----
// Byte selector: picks the file byte for a held pixel at a sequence position.
`default_nettype none
module bmp24_byte_sel
  import bmp24_pkg::*;
(
  input  item_t            item,
  input  logic [POS_W-1:0] pos,
  output logic [7:0]       data,
  output logic             last,
  output logic             done
);

  logic [31:0] total_len;
  logic [7:0]  hdr;

  // Header fields derived from the sizes captured with the first pixel
  assign total_len = 32'(item.img_size) + BITMAP_START;
  assign hdr = header_byte(pos, total_len, 32'(item.width), 32'(item.height),
                           32'(item.img_size));

  // Header, then pixel bytes B,G,R or a marker colour, then zero padding
  always_comb begin
    data = 8'd0;
    priority if (pos < HDR_BYTES) begin
      data = hdr;
    end else if (pos == PIX_FIRST) begin
      if (item.point_valid && item.height_nonzero) data = item.blue;
      else if (item.point_valid)                   data = NO_HEIGHT;
      else                                         data = BAD_POINT;
    end else if (pos == PIX_FIRST + 6'd1) begin
      data = (item.point_valid && item.height_nonzero) ? item.green : 8'd0;
    end else if (pos == PIX_LAST) begin
      data = (item.point_valid && item.height_nonzero) ? item.red : 8'd0;
    end else begin
      data = 8'd0;
    end
  end

  assign last = (pos == item.last_pos);
  assign done = last && item.img_end;

endmodule
`default_nettype wire

// ----- hw/rtl/bmp24_stream_encoder.sv -----
// Top level: 24-bit BMP file byte stream encoder.
// Pixels arrive in raster order, bottom row first, and leave as one byte per cycle on the
// stream channel while the sink is ready. The first pixel of each image is preceded by the
// 54-byte file and info headers built from the width and height in force when that pixel is
// taken; each pixel gives three bytes, and the last pixel of a row is followed by zero
// padding to a four-byte boundary. A new pixel is taken in the cycle its predecessor's last
// byte is loaded into the single output byte register, so back-to-back pixels leave no gap
// in the byte stream. Width and height written as 0 read as 1, and values above
// MAX_DIMENSION read as MAX_DIMENSION.
`default_nettype none
module bmp24_stream_encoder
  import bmp24_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  bmp24_pix_if.sink             pixel,
  bmp24_byte_if.source          stream,
  input  wire logic             wr_en,
  input  wire logic             wr_index,
  input  wire logic [DIM_W-1:0] wr_data
);

  localparam logic [16:0] MAX_DIM = 17'(MAX_DIMENSION);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] clamped;
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic             busy;
  logic [POS_W-1:0] pos;
  item_t            item;
  item_t            item_next;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_done;
  logic [7:0]       sel_data;
  logic             sel_last;
  logic             sel_done;
  logic             load_ok;
  logic             accept;
  logic             first_pix;
  logic             row_end;
  logic             img_end;
  logic [14:0]      row_bytes;

  // Configuration registers with range clamp
  always_comb begin
    priority if (wr_data == '0)            clamped = DIM_W'(1);
    else if (17'(wr_data) > MAX_DIM)       clamped = MAX_DIM[DIM_W-1:0];
    else                                   clamped = wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IMAGE_WIDTH:  image_width  <= clamped;
        REG_IMAGE_HEIGHT: image_height <= clamped;
        default: ;
      endcase
    end
  end

  // Handshake: a new word may load when the output register is free or being taken
  assign load_ok      = !out_valid || stream.ready;
  assign pixel.ready  = !busy || (load_ok && sel_last);
  assign accept       = pixel.valid && pixel.ready;

  // Row and image bookkeeping for the pixel being taken
  assign first_pix = (column_count == '0) && (row_count == '0);
  assign row_end   = ({1'b0, column_count} + 14'd1) >= {1'b0, image_width};
  assign img_end   = row_end && (({1'b0, row_count} + 14'd1) >= {1'b0, image_height});
  assign row_bytes = (15'(image_width) * 15'd3 + 15'd3) & ~15'd3;

  always_comb begin
    item_next.point_valid    = pixel.point_x_nonzero && pixel.point_y_nonzero;
    item_next.height_nonzero = pixel.height_nonzero;
    item_next.red            = pixel.red;
    item_next.green          = pixel.green;
    item_next.blue           = pixel.blue;
    // padding count equals the width modulo four
    item_next.last_pos       = PIX_LAST + (row_end ? {4'd0, image_width[1:0]} : 6'd0);
    item_next.img_end        = img_end;
    item_next.width          = image_width;
    item_next.height         = image_height;
    item_next.img_size       = IMG_W'(row_bytes) * IMG_W'(image_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= img_end ? '0 : row_count + DIM_W'(1);
      end else begin
        column_count <= column_count + DIM_W'(1);
      end
    end
  end

  // Held pixel and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      pos  <= first_pix ? '0 : PIX_FIRST;
    end else if (busy && load_ok) begin
      if (sel_last) busy <= 1'b0;
      else          pos  <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= item_next;
  end

  bmp24_byte_sel u_sel (
    .item (item),
    .pos  (pos),
    .data (sel_data),
    .last (sel_last),
    .done (sel_done)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && busy) begin
      out_byte <= sel_data;
      out_last <= sel_last;
      out_done <= sel_done;
    end
  end

  assign stream.valid        = out_valid;
  assign stream.out_byte     = out_byte;
  assign stream.last_of_item = out_last;
  assign stream.image_done   = out_done;

`ifndef SYNTHESIS
  // No new pixel while the held one still has bytes to go
  a_no_early_accept: assert property (@(posedge clk) disable iff (rst)
    busy && !sel_last |-> !pixel.ready)
    else $error("pixel taken before previous pixel finished");

  // Position never runs past the last byte of the held pixel
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos <= item.last_pos)
    else $error("byte position beyond end of pixel");

  // End of image only on the final word of a pixel
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("image_done without last_of_item");

  // The first pixel of an image always starts with the header
  a_header_first: assert property (@(posedge clk) disable iff (rst)
    accept && first_pix |=> pos == '0)
    else $error("image started without header");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the 24-bit BMP stream encoder: predicts every file byte and checks the stream.
`timescale 1ns / 100ps
module tb_top
  import bmp24_pkg::*;
();

  localparam int MAX_DIM      = 4096;
  localparam int TOTAL_PIXELS = 280;
  localparam int CALM_PIXELS  = 40;
  localparam int LONG_HOLD    = 300;
  localparam int WDOG_LIMIT   = 2000;

  // Fixed header fields
  localparam logic [15:0] BMP_MAGIC   = 16'h4D42;
  localparam logic [31:0] HDR_LEN     = 32'd54;
  localparam logic [31:0] INFO_LEN    = 32'd40;
  localparam logic [15:0] ONE_PLANE   = 16'd1;
  localparam logic [15:0] BPP_24      = 16'd24;
  localparam logic [31:0] RES_PPM     = 32'd2835;
  localparam logic [7:0]  FLAT_BLUE   = 8'd255;
  localparam logic [7:0]  BAD_BLUE    = 8'd127;

  typedef enum int {PIX_COLOUR, PIX_NO_HEIGHT, PIX_INVALID} pixel_kind_t;

  typedef struct {
    bit       x_nz;
    bit       y_nz;
    bit       h_nz;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       done;
  } file_word_t;

  // Scoreboard: tracks raster position and queues the file bytes each pixel must produce
  class bmp_file_predictor;
    int         width;
    int         height;
    int         col;
    int         row;
    file_word_t due[$];
    int         errors;
    int         checked;
    int         images;
    int         kind_count[3];

    function new();
      width  = 1;
      height = 1;
      col    = 0;
      row    = 0;
      errors = 0;
      checked = 0;
      images = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int row_len(int w);
      return ((24 * w + 31) / 32) * 4;
    endfunction

    function void set_dim(logic idx, logic [DIM_W-1:0] data);
      int v;
      v = int'(data);
      if (v == 0) v = 1;
      if (v > MAX_DIM) v = MAX_DIM;
      if (idx == REG_IMAGE_WIDTH) width = v;
      else height = v;
    endfunction

    function void push(logic [7:0] v);
      file_word_t w;
      w.value = v;
      w.last  = 1'b0;
      w.done  = 1'b0;
      due.push_back(w);
    endfunction

    // Note an accepted pixel and queue what it causes
    function void take_pixel(pixel_t p);
      logic [54*8-1:0] hdr;
      logic [31:0]     img;
      logic [31:0]     fsz;
      bit              ok;
      bit              img_end;
      int              pad;
      file_word_t      w;
      ok = p.x_nz && p.y_nz;
      img_end = 0;
      if (col == 0 && row == 0) begin
        img = row_len(width) * height;
        fsz = img + HDR_LEN;
        // Little-endian header, lowest byte first
        hdr = {32'd0, 32'd0, RES_PPM, RES_PPM, img, 32'd0, BPP_24, ONE_PLANE,
               32'(height), 32'(width), INFO_LEN, HDR_LEN, 32'd0, fsz, BMP_MAGIC};
        for (int i = 0; i < 54; i++) push(hdr[8*i +: 8]);
      end
      if (ok && p.h_nz) begin
        push(p.blue);
        push(p.green);
        push(p.red);
        kind_count[PIX_COLOUR]++;
      end else begin
        push(ok ? FLAT_BLUE : BAD_BLUE);
        push(8'd0);
        push(8'd0);
        if (ok) kind_count[PIX_NO_HEIGHT]++;
        else kind_count[PIX_INVALID]++;
      end
      // Row end pads to four bytes; image end wraps the raster
      if (col + 1 >= width) begin
        pad = row_len(width) - 3 * width;
        for (int i = 0; i < pad; i++) push(8'd0);
        col = 0;
        if (row + 1 >= height) begin
          img_end = 1;
          row = 0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
      w = due.pop_back();
      w.last = 1'b1;
      w.done = img_end;
      due.push_back(w);
    endfunction

    // Compare one accepted stream word with the oldest expectation
    function void check_word(logic [7:0] v, logic last, logic done);
      file_word_t e;
      checked++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got byte %02h last %0b done %0b",
                 $time, v, last, done);
        return;
      end
      e = due.pop_front();
      if (e.done) images++;
      if (v !== e.value || last !== e.last || done !== e.done) begin
        errors++;
        $display("%0t: word %0d: expected %02h last %0b done %0b, got %02h last %0b done %0b",
                 $time, checked, e.value, e.last, e.done, v, last, done);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic             wr_index;
  logic [DIM_W-1:0] wr_data;

  bmp24_pix_if  pix_ch ();
  bmp24_byte_if byte_ch ();

  bmp24_stream_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pix_ch),
    .stream   (byte_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  bmp_file_predictor pred = new();

  bit calm_tail = 0;
  bit hold_req  = 0;
  int sent      = 0;
  int held_for  = 0;
  int idle_cycles = 0;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Watch both channels and the register port
  always @(posedge clk) begin : monitor
    pixel_t seen;
    if (!rst) begin
      if (wr_en) pred.set_dim(wr_index, wr_data);
      if (pix_ch.valid && pix_ch.ready) begin
        seen.x_nz  = pix_ch.point_x_nonzero;
        seen.y_nz  = pix_ch.point_y_nonzero;
        seen.h_nz  = pix_ch.height_nonzero;
        seen.red   = pix_ch.red;
        seen.green = pix_ch.green;
        seen.blue  = pix_ch.blue;
        pred.take_pixel(seen);
      end
      if (byte_ch.valid && byte_ch.ready)
        pred.check_word(byte_ch.out_byte, byte_ch.last_of_item, byte_ch.image_done);
    end
  end

  // Watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d words outstanding",
                 $time, idle_cycles, pred.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stream sink: random stalls, one long hold-off on request, none in the tail
  initial begin
    byte_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        byte_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_for += LONG_HOLD;
        hold_req = 0;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        byte_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        byte_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic pixel_t px(bit x, bit y, bit h, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    pixel_t p;
    p.x_nz  = x;
    p.y_nz  = y;
    p.h_nz  = h;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  // Mostly valid coloured points, with flat and invalid ones mixed in
  function automatic pixel_t rand_pixel();
    return px($urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0, $urandom_range(0, 4) != 0,
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endfunction

  // Offer one pixel and hold it until taken
  task automatic send_pixel(input pixel_t p);
    if (!calm_tail && !hold_req && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    pix_ch.valid           <= 1'b1;
    pix_ch.point_x_nonzero <= p.x_nz;
    pix_ch.point_y_nonzero <= p.y_nz;
    pix_ch.height_nonzero  <= p.h_nz;
    pix_ch.red             <= p.red;
    pix_ch.green           <= p.green;
    pix_ch.blue            <= p.blue;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    sent++;
    if (sent >= TOTAL_PIXELS - CALM_PIXELS) calm_tail = 1;
  endtask

  // Stop offering and wait for every queued word
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
  endtask

  // Write both size registers; only called with the block idle
  task automatic set_size(input int w, input int h);
    wr_en    <= 1'b1;
    wr_index <= REG_IMAGE_WIDTH;
    wr_data  <= w[DIM_W-1:0];
    @(posedge clk);
    wr_index <= REG_IMAGE_HEIGHT;
    wr_data  <= h[DIM_W-1:0];
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int w;
    int h;
    int n;
    pix_ch.valid           <= 1'b0;
    pix_ch.point_x_nonzero <= 1'b0;
    pix_ch.point_y_nonzero <= 1'b0;
    pix_ch.height_nonzero  <= 1'b0;
    pix_ch.red             <= 8'd0;
    pix_ch.green           <= 8'd0;
    pix_ch.blue            <= 8'd0;
    wr_en                  <= 1'b0;
    wr_index               <= REG_IMAGE_WIDTH;
    wr_data                <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Reset size 1x1: every pixel is a whole image, each pixel kind
    send_pixel(px(1, 1, 1, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(px(1, 1, 1, 8'h00, 8'h00, 8'h00));
    send_pixel(px(1, 1, 0, 8'($urandom_range(0, 255)), 8'hA5, 8'h5A));
    send_pixel(px(0, 1, 1, 8'h12, 8'h34, 8'h56));
    send_pixel(px(1, 0, 1, 8'h65, 8'h43, 8'h21));
    send_pixel(px(0, 0, 0, 8'hFF, 8'h00, 8'hFF));
    drain();

    // Zero sizes read as one
    set_size(0, 0);
    send_pixel(rand_pixel());
    drain();

    // Oversize clamps to the maximum; then shrink mid-image to close row and image
    set_size(8191, 8191);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    drain();
    set_size(1, MAX_DIM);
    send_pixel(rand_pixel());
    drain();
    set_size(1, 1);
    send_pixel(rand_pixel());
    drain();

    // Just over the maximum, then a 2x2 finish from inside the first row
    set_size(MAX_DIM + 1, MAX_DIM);
    send_pixel(rand_pixel());
    drain();
    set_size(2, 2);
    repeat (3) send_pixel(rand_pixel());
    drain();

    // Three and four pixel rows: padding of three and of none
    set_size(3, 2);
    repeat (6) send_pixel(rand_pixel());
    drain();
    set_size(4, 1);
    repeat (4) send_pixel(rand_pixel());
    drain();

    // Random sizes and pixels; the first phase runs into the long sink hold-off
    hold_req = 1;
    while (sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 8191);
        1: w = MAX_DIM;
        default: w = $urandom_range(1, 9);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 8191);
        1: h = MAX_DIM;
        default: h = $urandom_range(1, 4);
      endcase
      set_size(w, h);
      n = $urandom_range(3, 36);
      if (n > TOTAL_PIXELS - sent) n = TOTAL_PIXELS - sent;
      repeat (n) send_pixel(rand_pixel());
      drain();
    end

    // Let any stray words show up
    repeat (20) @(posedge clk);

    $display("Covered %0d pixels (%0d coloured, %0d flat, %0d invalid) across %0d images.",
             sent, pred.kind_count[PIX_COLOUR], pred.kind_count[PIX_NO_HEIGHT],
             pred.kind_count[PIX_INVALID], pred.images);
    $display("Checked %0d words; sizes 1 to %0d incl. clamped writes; sink held off %0d cycles.",
             pred.checked, MAX_DIM, held_for);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d words never seen", pred.errors, pred.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
